>>> src/dshot_frame_serializer_assert.svh
// ----------------------------------------------------------------------------
// DShot frame serializer assertion macros
// Clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DSHOT_FRAME_SERIALIZER_ASSERT_SVH
`define DSHOT_FRAME_SERIALIZER_ASSERT_SVH

// same-cycle implication
`define DFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, constants and frame builder for the DShot frame serializer.
// ----------------------------------------------------------------------------
package dfs_pkg;

   localparam int MOTOR_COUNT_DEF = 4;
   localparam int SHOWN_MOTORS    = 4;   // motors with a compare port
   localparam int THR_WIDTH       = 11;  // DShot throttle value bits
   localparam int FRAME_WIDTH     = 16;
   localparam int POS_WIDTH       = 5;
   localparam int CMP_WIDTH       = 16;
   localparam int DATA_WIDTH      = 32;
   localparam int ADDR_WIDTH      = 3;

   localparam logic [POS_WIDTH-1:0] POS_FIRST = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_TRAIL = 5'd16;
   localparam logic [POS_WIDTH-1:0] POS_IDLE  = 5'd17;
   localparam logic [3:0]           FRAME_MSB = 4'd15;

   localparam logic [CMP_WIDTH-1:0] ONE_HIGH_RESET  = 16'd420;
   localparam logic [CMP_WIDTH-1:0] ZERO_HIGH_RESET = 16'd205;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   typedef enum logic {
      REG_ONE_HIGH  = 1'b0,
      REG_ZERO_HIGH = 1'b1
   } reg_index_type;

   // 11 throttle bits, telemetry bit, then XOR of the three nibbles
   function automatic logic [FRAME_WIDTH-1:0] build_frame(
      input logic [THR_WIDTH-1:0] value,
      input logic                 tel
   );
      logic [11:0] v;
      logic [3:0]  chk;
      v   = {value, tel};
      chk = v[3:0] ^ v[7:4] ^ v[11:8];
      return {v, chk};
   endfunction

endpackage

>>> src/dshot_frame_serializer.sv
// ----------------------------------------------------------------------------
// dshot_frame_serializer
// DShot transmitter: per-motor throttle store, frame build, bit sequencing.
// ----------------------------------------------------------------------------
// One beat on req_ is either a throttle write (kind 0) or a bit-period tick
// (kind 1). Writes store bits 15..5 of the throttle for one motor; a write to
// the last motor builds all frames (throttle, telemetry, 4-bit check) and
// restarts every line at its MSB, even mid-frame. Each tick returns one rsp_
// beat with the compare value for every motor's current bit, a zero compare
// for the trailing low period and for idle lines, and a mask of the lines
// that were sending or trailing. Writes return nothing. Throughput is one
// beat per clock unless a tick waits on rsp_stall: a beat first enters the
// input register, then its state update and compare selection land in the
// result register, which drives rsp_. A write leaves the input register
// even while a result is held by rsp_stall; a tick waits for the result
// register to free up. Compare registers live at byte offsets 0x0 (one bit)
// and 0x4 (zero bit) and should only be changed with the block quiet.
// ----------------------------------------------------------------------------
`include "dshot_frame_serializer_assert.svh"

module dshot_frame_serializer #(
   parameter int MOTOR_COUNT = dfs_pkg::MOTOR_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   // input beats
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [1:0]                     req_motor,
   input  logic [15:0]                    req_throttle,
   input  logic                           req_telemetry,

   // result beats
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dfs_pkg::CMP_WIDTH-1:0]  rsp_compare_m0,
   output logic [dfs_pkg::CMP_WIDTH-1:0]  rsp_compare_m1,
   output logic [dfs_pkg::CMP_WIDTH-1:0]  rsp_compare_m2,
   output logic [dfs_pkg::CMP_WIDTH-1:0]  rsp_compare_m3,
   output logic [3:0]                     rsp_active_mask,

   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dfs_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [dfs_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [dfs_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   localparam int SHOWN = dfs_pkg::SHOWN_MOTORS;

   // --- compare registers -------------------------------------------------
   logic [dfs_pkg::CMP_WIDTH-1:0] one_high_ff,  one_high_in;
   logic [dfs_pkg::CMP_WIDTH-1:0] zero_high_ff, zero_high_in;
   dfs_pkg::reg_index_type        reg_sel;
   logic                          reg_wr;

   assign pready  = 1'b1;
   assign reg_sel = dfs_pkg::reg_index_type'(paddr[2]);
   assign reg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      one_high_in  = one_high_ff;
      zero_high_in = zero_high_ff;
      if (reg_wr) begin
         case (reg_sel)
            dfs_pkg::REG_ONE_HIGH:  one_high_in  = pwdata[dfs_pkg::CMP_WIDTH-1:0];
            dfs_pkg::REG_ZERO_HIGH: zero_high_in = pwdata[dfs_pkg::CMP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         dfs_pkg::REG_ONE_HIGH:
            prdata = {{(dfs_pkg::DATA_WIDTH-dfs_pkg::CMP_WIDTH){1'b0}}, one_high_ff};
         dfs_pkg::REG_ZERO_HIGH:
            prdata = {{(dfs_pkg::DATA_WIDTH-dfs_pkg::CMP_WIDTH){1'b0}}, zero_high_ff};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= dfs_pkg::ONE_HIGH_RESET;
         zero_high_ff <= dfs_pkg::ZERO_HIGH_RESET;
      end else begin
         one_high_ff  <= one_high_in;
         zero_high_ff <= zero_high_in;
      end
   end

   // --- input register ----------------------------------------------------
   logic                        in_valid_ff, in_valid_in;
   dfs_pkg::kind_type           in_kind_ff,  in_kind_in;
   logic [1:0]                  in_motor_ff, in_motor_in;
   logic [dfs_pkg::THR_WIDTH-1:0] in_thr_ff, in_thr_in;
   logic                        in_tel_ff,   in_tel_in;

   logic out_free;   // result register can take a new beat
   logic advance;    // input register item is processed this cycle
   logic adv_write;
   logic adv_tick;
   logic build;      // write to the last motor
   logic req_take;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = in_valid_ff && ((in_kind_ff == dfs_pkg::KIND_WRITE) || out_free);
   assign adv_write = advance && (in_kind_ff == dfs_pkg::KIND_WRITE);
   assign adv_tick  = advance && (in_kind_ff == dfs_pkg::KIND_TICK);
   assign build     = adv_write && (int'(in_motor_ff) == MOTOR_COUNT - 1);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_motor_in = in_motor_ff;
      in_thr_in   = in_thr_ff;
      in_tel_in   = in_tel_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_kind_in  = dfs_pkg::kind_type'(req_kind);
         in_motor_in = req_motor;
         in_thr_in   = req_throttle[15:16-dfs_pkg::THR_WIDTH];
         in_tel_in   = req_telemetry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_kind_ff  <= in_kind_in;
      in_motor_ff <= in_motor_in;
      in_thr_ff   <= in_thr_in;
      in_tel_ff   <= in_tel_in;
   end

   // --- per-motor line state ----------------------------------------------
   logic [dfs_pkg::THR_WIDTH-1:0]   thr_ff   [MOTOR_COUNT];
   logic [dfs_pkg::THR_WIDTH-1:0]   thr_in   [MOTOR_COUNT];
   logic [dfs_pkg::FRAME_WIDTH-1:0] frame_ff [MOTOR_COUNT];
   logic [dfs_pkg::FRAME_WIDTH-1:0] frame_in [MOTOR_COUNT];
   logic [dfs_pkg::POS_WIDTH-1:0]   pos_ff   [MOTOR_COUNT];
   logic [dfs_pkg::POS_WIDTH-1:0]   pos_in   [MOTOR_COUNT];
   logic [dfs_pkg::CMP_WIDTH-1:0]   cmp_w    [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0]          act_w;

   always_comb begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         thr_in[m]   = thr_ff[m];
         frame_in[m] = frame_ff[m];
         pos_in[m]   = pos_ff[m];
         cmp_w[m]    = '0;
         act_w[m]    = 1'b0;

         // new throttle goes straight into this write's frame build
         if (adv_write && (int'(in_motor_ff) == m)) begin
            thr_in[m] = in_thr_ff;
         end
         if (build) begin
            frame_in[m] = dfs_pkg::build_frame(thr_in[m], in_tel_ff);
            pos_in[m]   = dfs_pkg::POS_FIRST;
         end

         if (pos_ff[m] < dfs_pkg::POS_TRAIL) begin
            cmp_w[m] = frame_ff[m][dfs_pkg::FRAME_MSB - pos_ff[m][3:0]] ?
                       one_high_ff : zero_high_ff;
         end
         act_w[m] = (pos_ff[m] <= dfs_pkg::POS_TRAIL);
         if (adv_tick && act_w[m]) begin
            pos_in[m] = pos_ff[m] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            thr_ff[m]   <= '0;
            frame_ff[m] <= '0;
            pos_ff[m]   <= dfs_pkg::POS_IDLE;
         end
      end else begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            thr_ff[m]   <= thr_in[m];
            frame_ff[m] <= frame_in[m];
            pos_ff[m]   <= pos_in[m];
         end
      end
   end

   // --- result register ---------------------------------------------------
   // only the first SHOWN motors have ports; missing motors read as zero
   logic [dfs_pkg::CMP_WIDTH-1:0] shown_cmp [SHOWN];
   logic [SHOWN-1:0]              shown_act;

   for (genvar s = 0; s < SHOWN; s++) begin : g_shown
      if (s < MOTOR_COUNT) begin : g_real
         assign shown_cmp[s] = cmp_w[s];
         assign shown_act[s] = act_w[s];
      end else begin : g_absent
         assign shown_cmp[s] = '0;
         assign shown_act[s] = 1'b0;
      end
   end

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dfs_pkg::CMP_WIDTH-1:0] rsp_cmp_ff [SHOWN];
   logic [dfs_pkg::CMP_WIDTH-1:0] rsp_cmp_in [SHOWN];
   logic [SHOWN-1:0]              rsp_mask_ff, rsp_mask_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      for (int s = 0; s < SHOWN; s++) begin
         rsp_cmp_in[s] = rsp_cmp_ff[s];
      end
      if (out_free) begin
         rsp_valid_in = adv_tick;
      end
      if (adv_tick) begin
         rsp_mask_in = shown_act;
         for (int s = 0; s < SHOWN; s++) begin
            rsp_cmp_in[s] = shown_cmp[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_mask_ff <= rsp_mask_in;
      for (int s = 0; s < SHOWN; s++) begin
         rsp_cmp_ff[s] <= rsp_cmp_in[s];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_compare_m0  = rsp_cmp_ff[0];
   assign rsp_compare_m1  = rsp_cmp_ff[1];
   assign rsp_compare_m2  = rsp_cmp_ff[2];
   assign rsp_compare_m3  = rsp_cmp_ff[3];
   assign rsp_active_mask = rsp_mask_ff;

   // --- checks ------------------------------------------------------------
   `DFS_ASSERT_NEXT(a_tick_gives_beat, adv_tick, rsp_valid_ff, "tick processed without result beat")
   `DFS_ASSERT_NEXT(a_build_restarts, build, pos_ff[0] == dfs_pkg::POS_FIRST, "frame build did not restart line 0")
   `DFS_ASSERT_NOW(a_cmp_implies_active, rsp_valid_ff && (rsp_cmp_ff[0] != '0), rsp_mask_ff[0], "nonzero compare on an inactive line")

endmodule
